// ===== rtl/tbk_pkg.sv =====
`timescale 1ns / 1ps

package tbk_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SEL_W       = 4;
  localparam int CMP_W       = (SLOT_W > SEL_W) ? SLOT_W : SEL_W;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    logic                   tick;
    logic                   alloc;
    logic                   query;
    logic [COUNT_WIDTH-1:0] count;
    logic [SEL_W-1:0]       sel;
  } cmd_t;

  // found: a free slot seen at or below this point of the row
  typedef struct packed {
    logic                   found;
    logic [SLOT_W-1:0]      idx;
    logic [COUNT_WIDTH-1:0] rd;
  } chain_t;

endpackage

// ===== rtl/tbk_cell.sv =====
`timescale 1ns / 1ps

module tbk_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tbk_pkg::SLOT_W-1:0] cell_id,
  input  tbk_pkg::cmd_t             cmd,
  input  tbk_pkg::chain_t           chain_in,
  output tbk_pkg::chain_t           chain_out
);
  import tbk_pkg::*;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   idle;
  logic                   grant;
  logic                   hit;

  assign idle  = (count_r == '0);
  assign grant = cmd.alloc && idle && !chain_in.found;
  assign hit   = cmd.query && (CMP_W'(cell_id) == CMP_W'(cmd.sel));

  always_comb begin
    count_nxt = count_r;
    priority if (cmd.tick && !idle) begin
      count_nxt = count_r - COUNT_WIDTH'(1);
    end else if (grant) begin
      count_nxt = cmd.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    chain_out.found = chain_in.found | idle;
    chain_out.idx   = chain_in.idx | (grant ? cell_id : '0);
    chain_out.rd    = chain_in.rd | (hit ? count_r : '0);
  end

endmodule

// ===== rtl/countdown_timer_bank.sv =====
`timescale 1ns / 1ps
// channel | dir | beat carries
// in_     | in  | tuser: op; tdata: count, slot_sel
// out_    | out | tdata: slot_index, alloc_fail, running, remaining
//
// One beat per cycle while in_tready is high; a result appears in the cycle after its input beat.
// Each slot is one cell of a row; first-free grant and query read ripple along the row.
// Reset clears all slots and the result valid flag.
// in_tready falls only while a held result is not taken.

module countdown_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic [39:0] in_tdata,   // [31:0] count, [35:32] slot_sel, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [3:0] slot_index, [4] alloc_fail, [5] running,
                                  // [37:6] remaining, rest zero
);
  import tbk_pkg::*;

  op_t         op;
  logic        acc;
  cmd_t        cmd;
  chain_t      chain [NUM_SLOTS+1];
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);

  always_comb begin
    cmd.tick  = acc && (op == OP_TICK);
    cmd.alloc = acc && (op == OP_ALLOC);
    cmd.query = acc && (op == OP_QUERY);
    cmd.count = COUNT_WIDTH'(in_tdata[31:0]);
    cmd.sel   = in_tdata[35:32];
  end

  assign chain[0] = '0;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    tbk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (SLOT_W'(k)),
      .cmd      (cmd),
      .chain_in (chain[k]),
      .chain_out(chain[k+1])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.alloc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {35'd0, !chain[NUM_SLOTS].found, 4'(chain[NUM_SLOTS].idx)};
    end else if (cmd.query) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'd0, 32'(chain[NUM_SLOTS].rd), (chain[NUM_SLOTS].rd != '0),
                       1'b0, cmd.sel};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/tbk_checker.sv =====
`timescale 1ns / 1ps

module tbk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  import tbk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid && !out_tready) |->
      $past(in_tvalid && in_tready &&
            (in_tuser == 2'(OP_ALLOC) || in_tuser == 2'(OP_QUERY))))
    else $error("result without an allocate or query beat");

  a_fail_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3:0] == 4'd0 && !out_tdata[5])
    else $error("failed allocate carries slot or running flag");

  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[37:6] != 32'd0 |-> out_tdata[5])
    else $error("ticks left but not running");

endmodule

bind countdown_timer_bank tbk_checker u_tbk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== bench/countdown_timer_bank_test.sv =====
`timescale 1ns / 1ps

module countdown_timer_bank_test;
  import tbk_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 450;
  localparam int          LONG_TICKS  = 100000;
  localparam int          DIR_ROWS    = 26;

  // slot_index in the lowest bits, as on out_tdata
  typedef struct packed {
    logic [31:0] remaining;
    logic        running;
    logic        alloc_fail;
    logic [3:0]  slot_index;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] count;
    logic [3:0]  sel;
    logic        typed;
    result_t     res;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_QUERY,  32'd0,        4'd0,  1'b1, '{32'd0,        1'b0, 1'b0, 4'd0}},
    '{OP_QUERY,  32'd0,        4'd15, 1'b1, '{32'd0,        1'b0, 1'b0, 4'd15}},
    '{OP_UNUSED, CNT_MAX,      4'd15, 1'b0, '0},
    '{OP_ALLOC,  32'd0,        4'd0,  1'b1, '{32'd0,        1'b0, 1'b0, 4'd0}},
    '{OP_ALLOC,  CNT_MAX,      4'd0,  1'b1, '{32'd0,        1'b0, 1'b0, 4'd0}},
    '{OP_QUERY,  32'd0,        4'd0,  1'b1, '{CNT_MAX,      1'b1, 1'b0, 4'd0}},
    '{OP_TICK,   32'd0,        4'd0,  1'b0, '0},
    '{OP_QUERY,  32'd0,        4'd0,  1'b1, '{32'hFFFF_FFFE, 1'b1, 1'b0, 4'd0}},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd1,        4'd0,  1'b0, '0},
    '{OP_ALLOC,  32'd5,        4'd7,  1'b1, '{32'd0,        1'b0, 1'b1, 4'd0}},
    '{OP_TICK,   32'd0,        4'd0,  1'b0, '0},
    '{OP_QUERY,  32'd0,        4'd1,  1'b0, '0}
  };

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser  = '0;
  logic [39:0] in_tdata  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  logic [COUNT_WIDTH-1:0] slot_ticks [NUM_SLOTS];
  result_t                pending_results [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int cycles    = 0;
  int n_ticks   = 0;
  int n_allocs  = 0;
  int n_refused = 0;
  int n_queries = 0;
  int n_unused  = 0;

  countdown_timer_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic bit step_bank(input logic [1:0] op, input logic [31:0] count,
                                   input logic [3:0] sel, output result_t res);
    logic [COUNT_WIDTH-1:0] v;
    bit                     granted;
    res     = '0;
    granted = 1'b0;
    v       = '0;
    case (op)
      OP_TICK: begin
        for (int k = 0; k < NUM_SLOTS; k++)
          if (slot_ticks[k] != 0) slot_ticks[k] = slot_ticks[k] - COUNT_WIDTH'(1);
        n_ticks++;
        return 1'b0;
      end
      OP_ALLOC: begin
        n_allocs++;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!granted && slot_ticks[k] == 0) begin
            slot_ticks[k]  = count;
            res.slot_index = 4'(k);
            granted        = 1'b1;
          end
        end
        if (!granted) begin
          res.alloc_fail = 1'b1;
          n_refused++;
        end
        return 1'b1;
      end
      OP_QUERY: begin
        n_queries++;
        if (int'(sel) < NUM_SLOTS) v = slot_ticks[sel];
        res.slot_index = sel;
        res.running    = (v != 0);
        res.remaining  = 32'(v);
        return 1'b1;
      end
      default: begin
        n_unused++;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [31:0] count,
                           input logic [3:0] sel, input bit typed, input result_t typed_res);
    result_t res;
    bit      has_res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, sel, count};
    do @(posedge clk); while (!in_tready);
    has_res = step_bank(op, count, sel, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[37:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.slot_index !== want.slot_index)
          report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
        if (got.alloc_fail !== want.alloc_fail)
          report_mismatch("alloc_fail", 32'(got.alloc_fail), 32'(want.alloc_fail));
        if (got.running !== want.running)
          report_mismatch("running", 32'(got.running), 32'(want.running));
        if (got.remaining !== want.remaining)
          report_mismatch("remaining", got.remaining, want.remaining);
      end
    end
  end

  initial begin
    int          idle_by_phase [4];
    int          stall_by_phase [4];
    int          sent;
    int          r;
    int          long_slots;
    logic [1:0]  op;
    logic [31:0] count;
    idle_by_phase  = '{0, 65, 0, 13};
    stall_by_phase = '{0, 0, 65, 13};
    for (int k = 0; k < NUM_SLOTS; k++) slot_ticks[k] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(DIRECTED[i].op, DIRECTED[i].count, DIRECTED[i].sel, DIRECTED[i].typed,
                DIRECTED[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      sent      = 0;
      while (sent < PHASE_ITEMS) begin
        r     = $urandom_range(0, 99);
        op    = (r < 34) ? OP_TICK : (r < 66) ? OP_ALLOC : (r < 95) ? OP_QUERY : OP_UNUSED;
        count = $urandom;
        if (op == OP_ALLOC) begin
          long_slots = 0;
          for (int k = 0; k < NUM_SLOTS; k++)
            if (slot_ticks[k] > LONG_TICKS) long_slots++;
          r = $urandom_range(0, 99);
          // long loads hold a slot for the rest of the run, so keep them rare
          if (r < 5)
            count = 32'd0;
          else if (r < 8 && long_slots < 4)
            count = (r < 6) ? CNT_MAX : $urandom;
          else
            count = $urandom_range(1, 24);
        end
        send_beat(op, count, 4'($urandom_range(0, 15)), 1'b0, '0);
        if (op != OP_UNUSED) sent++;
      end
    end

    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d ticks, %0d allocates (%0d refused as bank full), %0d queries",
             n_ticks, n_allocs, n_refused, n_queries);
    $display("     %0d unused-op beats, four idle/stall mixes, %0d mismatches",
             n_unused, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
